>>> sv/sixteen_bit_cpu_step_unit_assert.svh
// Assertion macros for the sixteen-bit CPU step unit.
// Included by the top level; depends on nothing else.
`ifndef SIXTEEN_BIT_CPU_STEP_UNIT_ASSERT_SVH
`define SIXTEEN_BIT_CPU_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SCPU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scpu: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SCPU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scpu: next-cycle check failed");

`endif

>>> sv/scpu_pkg.sv
// Shared constants, types and helpers of the sixteen-bit CPU step unit.
// Used by scpu_regfile, scpu_exec and the top level; depends on nothing.
package scpu_pkg;

   localparam int MEM_WORDS   = 65536;
   localparam int MEM_AW      = $clog2(MEM_WORDS);
   localparam int WORD_W      = 16;
   localparam int REG_AW      = 4;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [REG_AW-1:0] reg_idx_type;

   localparam word_type PORT_CHAR_IN  = 16'hF000;
   localparam word_type PORT_CHAR_OUT = 16'hF001;
   localparam word_type PORT_INT_IN   = 16'hF002;
   localparam word_type PORT_INT_OUT  = 16'hF003;
   localparam word_type HALT_WORD     = 16'hFFFF;
   localparam word_type STACK_RESET   = 16'h2000;

   localparam reg_idx_type REG_SP = 4'd14;
   localparam reg_idx_type REG_PC = 4'd15;

   typedef enum logic [3:0] {
      OP_JMP  = 4'h0,
      OP_JCC  = 4'h1,
      OP_LDR  = 4'h2,
      OP_STR  = 4'h3,
      OP_MOV  = 4'h4,
      OP_ADD  = 4'h5,
      OP_ADDI = 4'h6,
      OP_SUB  = 4'h7,
      OP_SUBI = 4'h8,
      OP_AND  = 4'h9,
      OP_OR   = 4'hA,
      OP_SHR  = 4'hB,
      OP_SHL  = 4'hC,
      OP_CMP  = 4'hD,
      OP_PUSH = 4'hE,
      OP_POP  = 4'hF
   } op_type;

   typedef enum logic [1:0] {
      COND_EQ = 2'd0,
      COND_NE = 2'd1,
      COND_LT = 2'd2,
      COND_GE = 2'd3
   } cond_type;

   typedef enum logic [RSP_TUSER_W-1:0] {
      IO_NONE     = 3'd0,
      IO_INT_OUT  = 3'd1,
      IO_CHAR_OUT = 3'd2,
      IO_INT_IN   = 3'd3,
      IO_CHAR_IN  = 3'd4
   } io_event_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_MEM
   } state_type;

   // Effects of one instruction, from the execute unit to the sequencer.
   typedef struct packed {
      logic         reg_we;
      reg_idx_type  reg_idx;
      word_type     reg_data;
      logic         pc_we;
      word_type     pc_data;
      logic         sp_we;
      word_type     sp_data;
      logic         z_we;
      logic         z_data;
      logic         c_we;
      logic         c_data;
      logic         mem_we;
      logic         mem_re;
      word_type     mem_addr;
      word_type     mem_data;
      logic         pop;
      logic         halt;
      io_event_type io_event;
      word_type     io_value;
   } exec_type;

   function automatic word_type sext8(logic [7:0] v);
      return {{8{v[7]}}, v};
   endfunction

endpackage

>>> sv/scpu_regfile.sv
// Register file of the CPU step unit: a 16-entry memory with registered reads.
// Depends on scpu_pkg; R14 and R15 live in the top level and are muxed in here.
module scpu_regfile (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  scpu_pkg::reg_idx_type rd_a_idx,
   input  scpu_pkg::reg_idx_type rd_b_idx,
   input  logic                 wr_en,
   input  scpu_pkg::reg_idx_type wr_idx,
   input  scpu_pkg::word_type   wr_data,
   input  scpu_pkg::word_type   pc,
   input  scpu_pkg::word_type   sp,
   output scpu_pkg::word_type   a_data,
   output scpu_pkg::word_type   b_data
);
   import scpu_pkg::*;

   word_type    reg_array [1 << REG_AW];
   logic [(1 << REG_AW)-1:0] valid_ff;
   word_type    a_raw_ff;
   word_type    b_raw_ff;
   reg_idx_type a_idx_ff;
   reg_idx_type b_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_array[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         a_raw_ff <= reg_array[rd_a_idx];
         b_raw_ff <= reg_array[rd_b_idx];
         a_idx_ff <= rd_a_idx;
         b_idx_ff <= rd_b_idx;
      end
   end

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      if (a_idx_ff == REG_PC) begin
         a_data = pc;
      end else if (a_idx_ff == REG_SP) begin
         a_data = sp;
      end else begin
         a_data = valid_ff[a_idx_ff] ? a_raw_ff : '0;
      end
      if (b_idx_ff == REG_PC) begin
         b_data = pc;
      end else if (b_idx_ff == REG_SP) begin
         b_data = sp;
      end else begin
         b_data = valid_ff[b_idx_ff] ? b_raw_ff : '0;
      end
   end

endmodule

>>> sv/scpu_exec.sv
// Execute unit of the CPU step unit: decodes one instruction and computes its effects.
// Depends on scpu_pkg; purely combinational.
module scpu_exec (
   input  scpu_pkg::word_type instr,
   input  scpu_pkg::word_type a_data,
   input  scpu_pkg::word_type b_data,
   input  scpu_pkg::word_type pc,
   input  scpu_pkg::word_type sp,
   input  logic               zero_flag,
   input  logic               carry_flag,
   input  scpu_pkg::word_type io_in,
   output scpu_pkg::exec_type result
);
   import scpu_pkg::*;

   op_type      op;
   reg_idx_type rd;
   reg_idx_type rn;
   word_type    simm8;
   word_type    operand_b;
   word_type    ldr_addr;
   word_type    str_addr;
   word_type    jump_target;
   logic [WORD_W:0] add_res;
   logic [WORD_W:0] sub_res;
   logic        take;

   assign op          = op_type'(instr[3:0]);
   assign rd          = instr[15:12];
   assign rn          = instr[7:4];
   assign simm8       = sext8(instr[11:4]);
   assign operand_b   = (op == OP_ADD || op == OP_SUB) ? b_data : {12'b0, rn};
   assign add_res     = {1'b0, a_data} + {1'b0, operand_b};
   assign sub_res     = {1'b0, a_data} - {1'b0, operand_b};
   assign ldr_addr    = a_data + {12'b0, rn};
   assign str_addr    = a_data + {12'b0, rd};
   assign jump_target = pc + simm8;

   always_comb begin
      case (cond_type'(instr[15:14]))
         COND_EQ: take = zero_flag;
         COND_NE: take = !zero_flag;
         COND_LT: take = !zero_flag && carry_flag;
         COND_GE: take = zero_flag || !carry_flag;
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      result          = '0;
      result.io_event = IO_NONE;
      result.reg_idx  = rd;
      unique case (op)
         OP_JMP: begin
            result.pc_we   = 1'b1;
            result.pc_data = jump_target;
         end
         OP_JCC: begin
            result.pc_we   = take;
            result.pc_data = jump_target;
         end
         OP_LDR: begin
            if (ldr_addr == PORT_INT_IN) begin
               result.reg_we   = 1'b1;
               result.reg_data = io_in;
               result.io_event = IO_INT_IN;
               result.io_value = io_in;
            end else if (ldr_addr == PORT_CHAR_IN) begin
               result.reg_we   = 1'b1;
               result.reg_data = sext8(io_in[7:0]);
               result.io_event = IO_CHAR_IN;
               result.io_value = sext8(io_in[7:0]);
            end else begin
               result.mem_re   = 1'b1;
               result.mem_addr = ldr_addr;
            end
         end
         OP_STR: begin
            if (str_addr == PORT_INT_OUT) begin
               result.io_event = IO_INT_OUT;
               result.io_value = b_data;
            end else if (str_addr == PORT_CHAR_OUT) begin
               result.io_event = IO_CHAR_OUT;
               result.io_value = {8'b0, b_data[7:0]};
            end else begin
               result.mem_we   = 1'b1;
               result.mem_addr = str_addr;
               result.mem_data = b_data;
            end
         end
         OP_MOV: begin
            result.reg_we   = 1'b1;
            result.reg_data = {8'b0, instr[11:4]};
         end
         OP_ADD, OP_ADDI: begin
            result.reg_we   = 1'b1;
            result.reg_data = add_res[WORD_W-1:0];
            result.z_we     = 1'b1;
            result.z_data   = (add_res[WORD_W-1:0] == '0);
            result.c_we     = 1'b1;
            result.c_data   = add_res[WORD_W];
         end
         OP_SUB, OP_SUBI: begin
            result.reg_we   = 1'b1;
            result.reg_data = sub_res[WORD_W-1:0];
            result.z_we     = 1'b1;
            result.z_data   = (sub_res[WORD_W-1:0] == '0);
            result.c_we     = 1'b1;
            result.c_data   = sub_res[WORD_W];
         end
         OP_AND: begin
            result.reg_we   = 1'b1;
            result.reg_data = a_data & b_data;
            result.z_we     = 1'b1;
            result.z_data   = ((a_data & b_data) == '0);
         end
         OP_OR: begin
            result.reg_we   = 1'b1;
            result.reg_data = a_data | b_data;
            result.z_we     = 1'b1;
            result.z_data   = ((a_data | b_data) == '0);
         end
         OP_SHR: begin
            result.reg_we   = 1'b1;
            result.reg_data = a_data >> rn;
            result.z_we     = 1'b1;
            result.z_data   = ((a_data >> rn) == '0);
         end
         OP_SHL: begin
            result.reg_we   = 1'b1;
            result.reg_data = a_data << rn;
            result.z_we     = 1'b1;
            result.z_data   = ((a_data << rn) == '0);
         end
         OP_CMP: begin
            result.z_we   = 1'b1;
            result.z_data = (a_data == b_data);
            result.c_we   = 1'b1;
            result.c_data = (a_data < b_data);
         end
         OP_PUSH: begin
            result.sp_we    = 1'b1;
            result.sp_data  = sp - 16'd1;
            result.mem_we   = 1'b1;
            result.mem_addr = sp - 16'd1;
            // Pushing the stack pointer stores its already decremented value.
            result.mem_data = (rn == REG_SP) ? sp - 16'd1 : b_data;
         end
         OP_POP: begin
            if (instr == HALT_WORD) begin
               result.halt = 1'b1;
            end else begin
               result.pop      = 1'b1;
               result.mem_re   = 1'b1;
               result.mem_addr = sp;
               result.sp_we    = 1'b1;
               result.sp_data  = sp + 16'd1;
            end
         end
         default: begin
            result.io_event = IO_NONE;
         end
      endcase
   end

endmodule

>>> sv/sixteen_bit_cpu_step_unit.sv
// Sixteen-bit CPU step unit. A load transaction or a step after HALT returns its result
// in the cycle after acceptance; a step goes through fetch, operand read and execute,
// and LDR from memory and POP add a memory state, since they need a second memory access.
// A new transaction is taken once the unit is idle again and the response register is free.
// After reset all 65536 words of main memory are swept to zero, one word a cycle,
// with req_tready low; registers reset to zero with R14 at 0x2000.
`include "sixteen_bit_cpu_step_unit_assert.svh"

module sixteen_bit_cpu_step_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: load_addr[15:0], load_data[15:0], io_in_value[15:0].
   input  logic [scpu_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // Field: func (0 memory load, 1 step).
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: pc[15:0], zero_flag, carry_flag, halted, io_value[15:0], zero fill.
   output logic [scpu_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Field: io_event[2:0].
   output logic [scpu_pkg::RSP_TUSER_W-1:0]      rsp_tuser
);
   import scpu_pkg::*;

   state_type    state_ff, state_in;
   logic [MEM_AW-1:0] clr_ff;
   word_type     pc_ff, pc_in;
   word_type     sp_ff, sp_in;
   logic         z_ff, z_in;
   logic         c_ff, c_in;
   logic         halt_ff, halt_in;
   word_type     io_in_ff;
   word_type     instr_ff;
   reg_idx_type  ld_idx_ff;
   logic         ld_pop_ff;
   logic         rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   io_event_type rsp_user_ff;

   word_type     mem_array [MEM_WORDS];
   word_type     mem_rdata_ff;
   logic         mem_we;
   logic         mem_re;
   logic [MEM_AW-1:0] mem_addr;
   word_type     mem_wdata;

   logic         req_accept;
   logic         out_free;
   logic         out_load;
   io_event_type out_event;
   word_type     out_value;
   logic         io_load;
   logic         instr_load;
   logic         pend_load;

   logic         rf_rd_en;
   logic         rf_wr_en;
   reg_idx_type  rf_wr_idx;
   word_type     rf_wr_data;
   word_type     rf_a_data;
   word_type     rf_b_data;
   exec_type     ex;
   word_type     mem_load_value;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign mem_load_value = (ld_pop_ff && ld_idx_ff == REG_SP) ?
                           mem_rdata_ff + 16'd1 : mem_rdata_ff;

   scpu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rf_rd_en),
      .rd_a_idx (mem_rdata_ff[11:8]),
      .rd_b_idx (mem_rdata_ff[7:4]),
      .wr_en    (rf_wr_en),
      .wr_idx   (rf_wr_idx),
      .wr_data  (rf_wr_data),
      .pc       (pc_ff),
      .sp       (sp_ff),
      .a_data   (rf_a_data),
      .b_data   (rf_b_data)
   );

   scpu_exec u_exec (
      .instr      (instr_ff),
      .a_data     (rf_a_data),
      .b_data     (rf_b_data),
      .pc         (pc_ff),
      .sp         (sp_ff),
      .zero_flag  (z_ff),
      .carry_flag (c_ff),
      .io_in      (io_in_ff),
      .result     (ex)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_tuser && !halt_ff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = ex.mem_re ? ST_MEM : ST_IDLE;
         ST_MEM:   state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = '0;
      mem_wdata  = '0;
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      z_in       = z_ff;
      c_in       = c_ff;
      halt_in    = halt_ff;
      out_load   = 1'b0;
      out_event  = IO_NONE;
      out_value  = '0;
      io_load    = 1'b0;
      instr_load = 1'b0;
      pend_load  = 1'b0;
      rf_rd_en   = 1'b0;
      rf_wr_en   = 1'b0;
      rf_wr_idx  = '0;
      rf_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         ST_IDLE: begin
            req_tready = out_free;
            if (req_accept) begin
               io_load = 1'b1;
               if (!req_tuser) begin
                  mem_we    = 1'b1;
                  mem_addr  = req_tdata[MEM_AW-1:0];
                  mem_wdata = req_tdata[31:16];
                  out_load  = 1'b1;
               end else if (halt_ff) begin
                  out_load = 1'b1;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = pc_ff[MEM_AW-1:0];
                  pc_in    = pc_ff + 16'd1;
               end
            end
         end
         ST_FETCH: begin
            instr_load = 1'b1;
            rf_rd_en   = 1'b1;
         end
         ST_EXEC: begin
            mem_we    = ex.mem_we;
            mem_re    = ex.mem_re;
            mem_addr  = ex.mem_addr[MEM_AW-1:0];
            mem_wdata = ex.mem_data;
            if (ex.pc_we) begin
               pc_in = ex.pc_data;
            end
            if (ex.sp_we) begin
               sp_in = ex.sp_data;
            end
            if (ex.z_we) begin
               z_in = ex.z_data;
            end
            if (ex.c_we) begin
               c_in = ex.c_data;
            end
            halt_in = halt_ff || ex.halt;
            if (ex.reg_we) begin
               if (ex.reg_idx == REG_PC) begin
                  pc_in = ex.reg_data;
               end else if (ex.reg_idx == REG_SP) begin
                  sp_in = ex.reg_data;
               end else begin
                  rf_wr_en   = 1'b1;
                  rf_wr_idx  = ex.reg_idx;
                  rf_wr_data = ex.reg_data;
               end
            end
            pend_load = ex.mem_re;
            out_load  = !ex.mem_re;
            out_event = ex.io_event;
            out_value = ex.io_value;
         end
         ST_MEM: begin
            if (ld_idx_ff == REG_PC) begin
               pc_in = mem_load_value;
            end else if (ld_idx_ff == REG_SP) begin
               sp_in = mem_load_value;
            end else begin
               rf_wr_en   = 1'b1;
               rf_wr_idx  = ld_idx_ff;
               rf_wr_data = mem_load_value;
            end
            out_load = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_data_in = {5'b0, out_value, halt_in, c_in, z_in, pc_in};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem_array[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         sp_ff        <= STACK_RESET;
         z_ff         <= 1'b0;
         c_ff         <= 1'b0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         pc_ff   <= pc_in;
         sp_ff   <= sp_in;
         z_ff    <= z_in;
         c_ff    <= c_in;
         halt_ff <= halt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (io_load) begin
         io_in_ff <= req_tdata[47:32];
      end
      if (instr_load) begin
         instr_ff <= mem_rdata_ff;
      end
      if (pend_load) begin
         ld_idx_ff <= ex.reg_idx;
         ld_pop_ff <= ex.pop;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= out_event;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `SCPU_ASSERT_IMP(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req_tready)
   `SCPU_ASSERT_NXT(a_halt_sticky, clock, reset, halt_ff, halt_ff)
   `SCPU_ASSERT_NXT(a_step_fetches, clock, reset, req_accept && req_tuser && !halt_ff, state_ff == ST_FETCH)
   `SCPU_ASSERT_IMP(a_quiet_io_value, clock, reset, rsp_tvalid && rsp_tuser == IO_NONE, rsp_tdata[34:19] == 16'd0)

endmodule

>>> sim/tb_sixteen_bit_cpu_step_unit.sv
// Self-checking testbench for sixteen_bit_cpu_step_unit. It feeds load and step transactions,
// including small programs with console I/O, stack use and branches.
// A scoreboard class holds a CPU model. Depends on scpu_pkg and the RTL of the unit.
module tb_sixteen_bit_cpu_step_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import scpu_pkg::*;

   typedef struct {
      word_type     pc;
      bit           zf;
      bit           cf;
      bit           halted;
      io_event_type ev;
      word_type     val;
   } cpu_report_type;

   class cpu_model_scoreboard;
      word_type    regs [16];
      word_type    mem [MEM_WORDS];
      bit          zf;
      bit          cf;
      bit          stopped;
      cpu_report_type expected_reports [$];
      int          errors;
      int          num_loads;
      int          num_steps;
      int          num_console;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         regs[REG_SP] = STACK_RESET;
      endfunction

      function void apply_item(bit func, word_type addr, word_type data, word_type io_in);
         cpu_report_type rep;
         word_type    w;
         word_type    a;
         word_type    b;
         word_type    ea;
         word_type    sx;
         word_type    res;
         logic [16:0] sum;
         op_type      op;
         reg_idx_type rd;
         reg_idx_type rm;
         reg_idx_type rn;
         logic [3:0]  imm4;
         logic [7:0]  imm8;
         bit          take;
         rep.ev = IO_NONE;
         rep.val = '0;
         if (!func) begin
            mem[addr] = data;
            num_loads++;
         end else begin
            num_steps++;
            if (!stopped) begin
               w = mem[regs[REG_PC]];
               regs[REG_PC] = regs[REG_PC] + 16'd1;
               op = op_type'(w[3:0]);
               rd = w[15:12];
               rm = w[11:8];
               rn = w[7:4];
               imm4 = w[7:4];
               imm8 = w[11:4];
               sx = {{8{imm8[7]}}, imm8};
               a = regs[rm];
               case (op)
                  OP_JMP: begin
                     regs[REG_PC] = regs[REG_PC] + sx;
                  end
                  OP_JCC: begin
                     case (cond_type'(w[15:14]))
                        COND_EQ: take = zf;
                        COND_NE: take = !zf;
                        COND_LT: take = !zf && cf;
                        default: take = zf || !cf;
                     endcase
                     if (take) regs[REG_PC] = regs[REG_PC] + sx;
                  end
                  OP_LDR: begin
                     ea = a + {12'h000, imm4};
                     if (ea == PORT_INT_IN) begin
                        regs[rd] = io_in;
                        rep.ev = IO_INT_IN;
                        rep.val = io_in;
                     end else if (ea == PORT_CHAR_IN) begin
                        regs[rd] = {{8{io_in[7]}}, io_in[7:0]};
                        rep.ev = IO_CHAR_IN;
                        rep.val = {{8{io_in[7]}}, io_in[7:0]};
                     end else begin
                        regs[rd] = mem[ea];
                     end
                  end
                  OP_STR: begin
                     ea = a + {12'h000, rd};
                     if (ea == PORT_INT_OUT) begin
                        rep.ev = IO_INT_OUT;
                        rep.val = regs[rn];
                     end else if (ea == PORT_CHAR_OUT) begin
                        rep.ev = IO_CHAR_OUT;
                        rep.val = {8'h00, regs[rn][7:0]};
                     end else begin
                        mem[ea] = regs[rn];
                     end
                  end
                  OP_MOV: begin
                     regs[rd] = {8'h00, imm8};
                  end
                  OP_ADD, OP_ADDI: begin
                     b = (op == OP_ADD) ? regs[rn] : {12'h000, imm4};
                     sum = {1'b0, a} + {1'b0, b};
                     regs[rd] = sum[15:0];
                     zf = (sum[15:0] == '0);
                     cf = sum[16];
                  end
                  OP_SUB, OP_SUBI: begin
                     b = (op == OP_SUB) ? regs[rn] : {12'h000, imm4};
                     res = a - b;
                     regs[rd] = res;
                     zf = (res == '0);
                     cf = (a < b);
                  end
                  OP_AND, OP_OR, OP_SHR, OP_SHL: begin
                     case (op)
                        OP_AND:  res = a & regs[rn];
                        OP_OR:   res = a | regs[rn];
                        OP_SHR:  res = a >> imm4;
                        default: res = a << imm4;
                     endcase
                     regs[rd] = res;
                     zf = (res == '0);
                  end
                  OP_CMP: begin
                     zf = (a == regs[rn]);
                     cf = (a < regs[rn]);
                  end
                  OP_PUSH: begin
                     regs[REG_SP] = regs[REG_SP] - 16'd1;
                     mem[regs[REG_SP]] = regs[rn];
                  end
                  default: begin
                     if (w == HALT_WORD) begin
                        stopped = 1'b1;
                     end else begin
                        regs[rd] = mem[regs[REG_SP]];
                        regs[REG_SP] = regs[REG_SP] + 16'd1;
                     end
                  end
               endcase
               if (rep.ev != IO_NONE) num_console++;
            end
         end
         rep.pc = regs[REG_PC];
         rep.zf = zf;
         rep.cf = cf;
         rep.halted = stopped;
         expected_reports.push_back(rep);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] tdata, logic [RSP_TUSER_W-1:0] tuser);
         cpu_report_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected result transaction: pc %h, io_event %0d", tdata[15:0], tuser);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         if (tdata[15:0] !== want.pc) begin
            $error("pc: expected %h, got %h", want.pc, tdata[15:0]);
            errors++;
         end
         if (tdata[16] !== want.zf) begin
            $error("zero_flag: expected %0d, got %0d", want.zf, tdata[16]);
            errors++;
         end
         if (tdata[17] !== want.cf) begin
            $error("carry_flag: expected %0d, got %0d", want.cf, tdata[17]);
            errors++;
         end
         if (tdata[18] !== want.halted) begin
            $error("halted: expected %0d, got %0d", want.halted, tdata[18]);
            errors++;
         end
         if (tuser !== want.ev) begin
            $error("io_event: expected %0d, got %0d", want.ev, tuser);
            errors++;
         end
         if (tdata[34:19] !== want.val) begin
            $error("io_value: expected %h, got %h", want.val, tdata[34:19]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   cpu_model_scoreboard sb = new();
   int                  items_sent = 0;
   bit                  quiet = 1'b0;

   sixteen_bit_cpu_step_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5ns clock = ~clock;

   initial rsp_tready = 1'b0;

   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 34);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   task automatic send_item(bit func, word_type addr, word_type data, word_type io_in);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {io_in, data, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.apply_item(func, addr, data, io_in);
      items_sent++;
      quiet = (items_sent >= 400 && items_sent < 520);
   endtask

   // A HALT under the PC is overwritten first, so the CPU only stops at the very end.
   task automatic step_cpu(word_type io_in);
      word_type w;
      if (sb.mem[sb.regs[REG_PC]] == HALT_WORD) begin
         w = rand_word();
         if (w == HALT_WORD) w[0] = 1'b0;
         send_item(1'b0, sb.regs[REG_PC], w, rand_word());
      end
      send_item(1'b1, rand_word(), rand_word(), io_in);
   endtask

   task automatic load_at_pc(word_type prog [$]);
      word_type base;
      base = sb.regs[REG_PC];
      foreach (prog[i]) send_item(1'b0, base + word_type'(i), prog[i], rand_word());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
   endtask

   function automatic void add_snippet(ref word_type prog [$]);
      reg_idx_type rx;
      reg_idx_type ry;
      word_type    w;
      rx = reg_idx_type'($urandom_range(1, 13));
      ry = reg_idx_type'($urandom);
      w = rand_word();
      case ($urandom_range(0, 5))
         0: begin
            prog.push_back({rx, PORT_CHAR_IN[15:8], OP_MOV});
            prog.push_back({rx, rx, 4'd8, OP_SHL});
            case ($urandom_range(0, 3))
               0: prog.push_back({ry, rx, PORT_INT_IN[3:0], OP_LDR});
               1: prog.push_back({ry, rx, PORT_CHAR_IN[3:0], OP_LDR});
               2: prog.push_back({PORT_INT_OUT[3:0], rx, ry, OP_STR});
               default: prog.push_back({PORT_CHAR_OUT[3:0], rx, ry, OP_STR});
            endcase
         end
         1: begin
            prog.push_back({4'h0, rx, ry, OP_CMP});
            w[3:0] = OP_JCC;
            if ($urandom_range(0, 3) != 0) w[11:4] = 8'($urandom_range(0, 3));
            prog.push_back(w);
         end
         2: begin
            prog.push_back({4'h0, 4'h0, ry, OP_PUSH});
            w[3:0] = OP_POP;
            prog.push_back(w);
         end
         3: begin
            w[3:0] = OP_MOV;
            w[15:12] = rx;
            prog.push_back(w);
         end
         4: begin
            w[3:0] = 4'($urandom_range(OP_ADD, OP_CMP));
            w[15:12] = rx;
            prog.push_back(w);
         end
         default: prog.push_back(w);
      endcase
      foreach (prog[i]) if (prog[i] == HALT_WORD) prog[i][0] = 1'b0;
   endfunction

   initial begin
      word_type prog [$];
      word_type io_vals [$];
      int       n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(1'b0, 16'hFFFF, HALT_WORD, 16'hFFFF);
      prog = '{
         {4'h1, PORT_CHAR_IN[15:8], OP_MOV},
         {4'h1, 4'h1, 4'd8, OP_SHL},
         {4'h2, 4'h1, PORT_INT_IN[3:0], OP_LDR},
         {4'h3, 4'h1, PORT_CHAR_IN[3:0], OP_LDR},
         {PORT_INT_OUT[3:0], 4'h1, 4'h2, OP_STR},
         {PORT_CHAR_OUT[3:0], 4'h1, 4'h3, OP_STR},
         {4'h4, 4'h2, 4'h2, OP_ADD},
         {4'h5, 4'h3, 4'h2, OP_SUB},
         {4'h0, 4'h0, REG_SP, OP_PUSH},
         {REG_SP, 4'h0, 4'h0, OP_POP},
         {REG_PC, 8'h20, OP_MOV}
      };
      io_vals = '{16'h0000, 16'h5A5A, 16'hFFFF, 16'h0080, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
      load_at_pc(prog);
      foreach (io_vals[i]) step_cpu(io_vals[i]);
      drain_results();

      while (items_sent < 830) begin
         case ($urandom_range(0, 9))
            7: repeat ($urandom_range(1, 3)) send_item(1'b0, rand_word(), rand_word(), rand_word());
            8: repeat ($urandom_range(1, 4)) step_cpu(rand_word());
            9: drain_results();
            default: begin
               prog.delete();
               n = $urandom_range(3, 12);
               while (prog.size() < n) add_snippet(prog);
               load_at_pc(prog);
               repeat (prog.size() + $urandom_range(0, 3)) step_cpu(rand_word());
            end
         endcase
      end

      send_item(1'b0, sb.regs[REG_PC], HALT_WORD, rand_word());
      send_item(1'b1, rand_word(), rand_word(), rand_word());
      send_item(1'b1, rand_word(), rand_word(), rand_word());
      send_item(1'b0, rand_word(), rand_word(), rand_word());
      send_item(1'b1, rand_word(), rand_word(), rand_word());
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d memory loads and %0d steps, %0d of them with console traffic,",
               sb.num_loads, sb.num_steps, sb.num_console);
      $display("ending with a HALT followed by steps and a load on the stopped CPU.");
      if (sb.errors == 0) begin
         $display("tb_sixteen_bit_cpu_step_unit: clean");
      end else begin
         $display("tb_sixteen_bit_cpu_step_unit: errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_sixteen_bit_cpu_step_unit: errors");
      $finish;
   end

endmodule
